@@ hw/rtl/fir10_pkg.sv @@
package fir10_pkg;

   localparam int TAP_COUNT_DEFAULT   = 10;
   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int OUT_BITS            = 11;
   localparam int COEF_BITS           = 9;
   localparam int COEF_COUNT          = 11;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   localparam coef_type COEF_TABLE [COEF_COUNT] = '{
      coef_type'(-1), coef_type'(-7), coef_type'(-13), coef_type'(32),
      coef_type'(140), coef_type'(203), coef_type'(140), coef_type'(32),
      coef_type'(-13), coef_type'(-7), coef_type'(-1)
   };

   typedef logic signed [OUT_BITS-1:0] out_sample_type;

endpackage

@@ hw/rtl/fir10_tap_sum.sv @@
module fir10_tap_sum #(
   parameter int TAP_COUNT   = fir10_pkg::TAP_COUNT_DEFAULT,
   parameter int SAMPLE_BITS = fir10_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic signed [SAMPLE_BITS-1:0] taps [TAP_COUNT],
   output fir10_pkg::out_sample_type     sum
);
   import fir10_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int SHIFT     = SAMPLE_BITS - 1;
   localparam int TERM_BITS = PROD_BITS - SHIFT;

   out_sample_type terms [TAP_COUNT];

   // Each product is floor-shifted by dropping its low bits before the sum.
   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
      logic signed [PROD_BITS-1:0] prod;
      logic signed [TERM_BITS-1:0] term;
      assign prod     = PROD_BITS'(taps[k]) * PROD_BITS'(COEF_TABLE[k]);
      assign term     = signed'(prod[PROD_BITS-1:SHIFT]);
      assign terms[k] = OUT_BITS'(term);
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < TAP_COUNT; k++) begin
         sum = sum + terms[k];
      end
   end

endmodule

@@ hw/rtl/fir_filter_ten_tap.sv @@
// Channel   Direction  Payload (lowest bit up)
// req_      in         tdata: sample_in (SAMPLE_BITS, signed), zero padded to bytes
// rsp_      out        tdata: sample_out (11, signed), zero padded to 16 bits
//
// Each request passes from acceptance through the tap window register and then
// the response register.
// A new request can be accepted every cycle while the response is not stalled;
// the ten constant multipliers and their adder run in parallel between the two registers.
// Reset clears the delay line to zero and drops any request in flight.
// A stalled response holds both stages, and the window shifts only on acceptance.
module fir_filter_ten_tap #(
   parameter int TAP_COUNT   = fir10_pkg::TAP_COUNT_DEFAULT,
   parameter int SAMPLE_BITS = fir10_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // sample_in
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [((fir10_pkg::OUT_BITS + 7) / 8) * 8 - 1:0] rsp_tdata  // sample_out
);
   import fir10_pkg::*;

   localparam int RSP_BITS = ((OUT_BITS + 7) / 8) * 8;

   logic signed [SAMPLE_BITS-1:0] window_ff [TAP_COUNT];
   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   out_sample_type                rsp_sample_ff;
   out_sample_type                sum;
   logic                          rsp_free;
   logic                          stage_move;
   logic                          req_take;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign stage_move = stage_valid_ff && rsp_free;
   assign req_tready = !stage_valid_ff || rsp_free;
   assign req_take   = req_tvalid && req_tready;

   assign stage_valid_in = req_take || (stage_valid_ff && !rsp_free);
   assign rsp_valid_in   = stage_move || (rsp_valid_ff && !rsp_tready);

   fir10_tap_sum #(
      .TAP_COUNT   (TAP_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tap_sum (
      .taps (window_ff),
      .sum  (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k < TAP_COUNT; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (req_take) begin
            window_ff[0] <= signed'(req_tdata[SAMPLE_BITS-1:0]);
            for (int k = 1; k < TAP_COUNT; k++) begin
               window_ff[k] <= window_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_move) begin
         rsp_sample_ff <= sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(unsigned'(rsp_sample_ff));

endmodule
